[hw/rtl/imhq_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// imhq_pkg
// Shared types and constants of the indexed min-heap event queue.
// ----------------------------------------------------------------------------
package imhq_pkg;

  localparam int CAPACITY_DEF  = 64;
  localparam int TIME_BITS_DEF = 32;
  localparam int LIMIT_W       = 7;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

  typedef enum logic {
    CMD_ADD    = 1'b0,
    CMD_UPDATE = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_NO_ID = 2'd2
  } status_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [5:0]  event_id;
    logic [31:0] event_time;
  } req_t;

  typedef struct packed {
    logic [5:0]  front_id;
    logic [31:0] front_time;
    logic [6:0]  event_count;
    logic [5:0]  assigned_id;
    status_t     status;
  } rsp_t;

  typedef enum logic [3:0] {
    S_IDLE, S_SID, S_OLD, S_CMPOLD, S_UP, S_UPCMP, S_DOWN, S_DN1, S_DN2,
    S_DNCMP, S_PLACE, S_FRONT, S_FRONTRD, S_OUT
  } state_t;

  typedef struct packed {
    logic slot_we;
    logic sid_we;
  } store_ctl_t;

endpackage
`default_nettype wire

[hw/rtl/imhq_store.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// imhq_store
// Heap slot memory (id and time per slot) and slot-of-id memory, each with
// one write port and one registered read port.
// ----------------------------------------------------------------------------
module imhq_store #(
  parameter int CAPACITY  = imhq_pkg::CAPACITY_DEF,
  parameter int TIME_BITS = imhq_pkg::TIME_BITS_DEF,
  localparam int IW = $clog2(CAPACITY)
) (
  input  wire logic                 clk,
  input  wire imhq_pkg::store_ctl_t ctl,
  input  wire logic [IW-1:0]        slot_waddr,
  input  wire logic [IW-1:0]        slot_wid,
  input  wire logic [TIME_BITS-1:0] slot_wtime,
  input  wire logic [IW-1:0]        slot_raddr,
  output logic      [IW-1:0]        slot_rid,
  output logic      [TIME_BITS-1:0] slot_rtime,
  input  wire logic [IW-1:0]        sid_waddr,
  input  wire logic [IW-1:0]        sid_wdata,
  input  wire logic [IW-1:0]        sid_raddr,
  output logic      [IW-1:0]        sid_rdata
);

  logic [IW-1:0]        slot_id_mem   [CAPACITY];
  logic [TIME_BITS-1:0] slot_time_mem [CAPACITY];
  logic [IW-1:0]        sid_mem       [CAPACITY];

  always_ff @(posedge clk) begin
    if (ctl.slot_we) begin
      slot_id_mem[slot_waddr]   <= slot_wid;
      slot_time_mem[slot_waddr] <= slot_wtime;
    end
    slot_rid   <= slot_id_mem[slot_raddr];
    slot_rtime <= slot_time_mem[slot_raddr];
  end

  always_ff @(posedge clk) begin
    if (ctl.sid_we) begin
      sid_mem[sid_waddr] <= sid_wdata;
    end
    sid_rdata <= sid_mem[sid_raddr];
  end

endmodule
`default_nettype wire

[hw/rtl/indexed_min_heap_event_queue_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// indexed_min_heap_event_queue_top
// Indexed binary min-heap of event times with add and update commands.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid / req_stall / req) carries one command transaction:
//   add a new event time under the next free id, or update an existing id.
//   rsp channel (rsp_valid / rsp_stall / rsp) returns one transaction per
//   command: front id and time, event count, assigned id and status.
//   cfg_we / cfg_data write capacity_limit; write only while idle.
// Sequence: a refused command goes straight to the front read and the
//   result; an add sifts up with one parent read and compare per level; an
//   update first reads the slot of its id and its old time, then rises the
//   same way, stays, or sinks, reading two children per level through the
//   single memory read port.
//   One command is in flight at a time; req_stall is high until the result
//   has been taken.
// Reset: the heap becomes empty and capacity_limit returns to 64; no memory
//   clearing pass is needed since only entries below the count are read.
// Stall: a result waits in the output register while rsp_stall is high, and
//   no new command is taken meanwhile.
// ----------------------------------------------------------------------------
module indexed_min_heap_event_queue_top #(
  parameter int CAPACITY  = imhq_pkg::CAPACITY_DEF,
  parameter int TIME_BITS = imhq_pkg::TIME_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            req_valid,
  output logic                                 req_stall,
  input  wire imhq_pkg::req_t                  req,
  output logic                                 rsp_valid,
  input  wire logic                            rsp_stall,
  output imhq_pkg::rsp_t                       rsp,
  input  wire logic                            cfg_we,
  input  wire logic [imhq_pkg::LIMIT_W-1:0]    cfg_data
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int LW = (CW > imhq_pkg::LIMIT_W) ? CW : imhq_pkg::LIMIT_W;

  imhq_pkg::state_t state, state_next;

  logic [imhq_pkg::LIMIT_W-1:0] cap_reg;
  logic [CW-1:0]        held_count;
  logic [5:0]           id_reg;
  logic [IW-1:0]        pos;      // current hole position
  logic [IW-1:0]        nxt;      // parent or chosen child
  logic [IW-1:0]        mid;      // moving id
  logic [TIME_BITS-1:0] mtm;      // moving time
  logic [IW-1:0]        ctid;     // earlier child id
  logic [TIME_BITS-1:0] ctm;      // earlier child time
  logic [5:0]           assigned;
  imhq_pkg::status_t    status;

  imhq_pkg::store_ctl_t ctl;
  logic [IW-1:0]        slot_waddr, slot_wid, slot_raddr, slot_rid;
  logic [TIME_BITS-1:0] slot_wtime, slot_rtime;
  logic [IW-1:0]        sid_waddr, sid_wdata, sid_raddr, sid_rdata;

  logic                 req_acc;
  logic [LW-1:0]        limit;
  logic                 can_add, id_ok;
  logic [IW-1:0]        parent;
  logic [IW:0]          child1;
  logic                 child1_ok, child2_ok;
  logic [TIME_BITS-1:0] cmp_a, cmp_b;
  logic                 cmp_lt, cmp_eq;

  assign req_acc   = req_valid && !req_stall;
  assign req_stall = (state != imhq_pkg::S_IDLE);
  assign rsp_valid = (state == imhq_pkg::S_OUT);

  // Clamp the limit to the physical capacity
  assign limit   = (LW'(cap_reg) > LW'(CAPACITY)) ? LW'(CAPACITY) : LW'(cap_reg);
  assign can_add = LW'(held_count) < limit;
  assign id_ok   = LW'(req.event_id) < LW'(held_count);

  assign parent    = (pos - IW'(1)) >> 1;
  assign child1    = {pos, 1'b1};
  assign child1_ok = child1 < (IW + 1)'(held_count);
  assign child2_ok = ((IW + 1)'(nxt) + (IW + 1)'(1)) < (IW + 1)'(held_count);

  // Shared time comparator
  always_comb begin
    cmp_a = mtm;
    cmp_b = slot_rtime;
    unique case (state)
      imhq_pkg::S_DN2:   begin cmp_a = slot_rtime; cmp_b = ctm; end
      imhq_pkg::S_DNCMP: begin cmp_a = mtm;        cmp_b = ctm; end
      default:           begin cmp_a = mtm;        cmp_b = slot_rtime; end
    endcase
  end
  assign cmp_lt = cmp_a < cmp_b;
  assign cmp_eq = cmp_a == cmp_b;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      imhq_pkg::S_IDLE: begin
        if (req_acc) begin
          if (req.cmd == imhq_pkg::CMD_ADD) begin
            state_next = can_add ? imhq_pkg::S_UP : imhq_pkg::S_FRONT;
          end else begin
            state_next = id_ok ? imhq_pkg::S_SID : imhq_pkg::S_FRONT;
          end
        end
      end
      imhq_pkg::S_SID: state_next = imhq_pkg::S_OLD;
      imhq_pkg::S_OLD: state_next = imhq_pkg::S_CMPOLD;
      imhq_pkg::S_CMPOLD: begin
        priority if (cmp_lt) state_next = imhq_pkg::S_UP;
        else if (cmp_eq)     state_next = imhq_pkg::S_PLACE;
        else                 state_next = imhq_pkg::S_DOWN;
      end
      imhq_pkg::S_UP: begin
        state_next = (pos == '0) ? imhq_pkg::S_PLACE : imhq_pkg::S_UPCMP;
      end
      imhq_pkg::S_UPCMP: begin
        state_next = cmp_lt ? imhq_pkg::S_UP : imhq_pkg::S_PLACE;
      end
      imhq_pkg::S_DOWN: begin
        state_next = child1_ok ? imhq_pkg::S_DN1 : imhq_pkg::S_PLACE;
      end
      imhq_pkg::S_DN1: begin
        state_next = child2_ok ? imhq_pkg::S_DN2 : imhq_pkg::S_DNCMP;
      end
      imhq_pkg::S_DN2: state_next = imhq_pkg::S_DNCMP;
      imhq_pkg::S_DNCMP: begin
        state_next = cmp_lt ? imhq_pkg::S_PLACE : imhq_pkg::S_DOWN;
      end
      imhq_pkg::S_PLACE:   state_next = imhq_pkg::S_FRONT;
      imhq_pkg::S_FRONT:   state_next = imhq_pkg::S_FRONTRD;
      imhq_pkg::S_FRONTRD: state_next = imhq_pkg::S_OUT;
      imhq_pkg::S_OUT: begin
        if (!rsp_stall) state_next = imhq_pkg::S_IDLE;
      end
      default: state_next = imhq_pkg::S_IDLE;
    endcase
  end

  // Memory controls
  always_comb begin
    ctl        = '0;
    slot_waddr = pos;
    slot_wid   = mid;
    slot_wtime = mtm;
    sid_waddr  = mid;
    sid_wdata  = pos;
    slot_raddr = '0;
    sid_raddr  = IW'(id_reg);
    unique case (state)
      imhq_pkg::S_OLD:  slot_raddr = sid_rdata;
      imhq_pkg::S_UP:   slot_raddr = parent;
      imhq_pkg::S_DOWN: slot_raddr = IW'(child1);
      imhq_pkg::S_DN1:  slot_raddr = nxt + IW'(1);
      imhq_pkg::S_UPCMP: begin
        // drop the parent into the hole
        ctl.slot_we = cmp_lt;
        ctl.sid_we  = cmp_lt;
        slot_wid    = slot_rid;
        slot_wtime  = slot_rtime;
        sid_waddr   = slot_rid;
      end
      imhq_pkg::S_DNCMP: begin
        // lift the earlier child into the hole
        ctl.slot_we = !cmp_lt;
        ctl.sid_we  = !cmp_lt;
        slot_wid    = ctid;
        slot_wtime  = ctm;
        sid_waddr   = ctid;
      end
      imhq_pkg::S_PLACE: begin
        ctl.slot_we = 1'b1;
        ctl.sid_we  = 1'b1;
      end
      default: ;
    endcase
  end

  imhq_store #(
    .CAPACITY  (CAPACITY),
    .TIME_BITS (TIME_BITS)
  ) u_store (
    .clk        (clk),
    .ctl        (ctl),
    .slot_waddr (slot_waddr),
    .slot_wid   (slot_wid),
    .slot_wtime (slot_wtime),
    .slot_raddr (slot_raddr),
    .slot_rid   (slot_rid),
    .slot_rtime (slot_rtime),
    .sid_waddr  (sid_waddr),
    .sid_wdata  (sid_wdata),
    .sid_raddr  (sid_raddr),
    .sid_rdata  (sid_rdata)
  );

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= imhq_pkg::S_IDLE;
      cap_reg    <= imhq_pkg::LIMIT_RESET;
      held_count <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) cap_reg <= cfg_data;
      if (req_acc && req.cmd == imhq_pkg::CMD_ADD && can_add) begin
        held_count <= held_count + CW'(1);
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      imhq_pkg::S_IDLE: begin
        id_reg   <= req.event_id;
        mtm      <= TIME_BITS'(req.event_time);
        assigned <= '0;
        if (req.cmd == imhq_pkg::CMD_ADD) begin
          status   <= can_add ? imhq_pkg::ST_OK : imhq_pkg::ST_FULL;
          pos      <= IW'(held_count);
          mid      <= IW'(held_count);
          assigned <= can_add ? 6'(held_count) : 6'd0;
        end else begin
          status <= id_ok ? imhq_pkg::ST_OK : imhq_pkg::ST_NO_ID;
          mid    <= IW'(req.event_id);
        end
      end
      imhq_pkg::S_OLD: pos <= sid_rdata;
      imhq_pkg::S_UP:  nxt <= parent;
      imhq_pkg::S_UPCMP: begin
        if (cmp_lt) pos <= nxt;
      end
      imhq_pkg::S_DOWN: nxt <= IW'(child1);
      imhq_pkg::S_DN1: begin
        ctid <= slot_rid;
        ctm  <= slot_rtime;
      end
      imhq_pkg::S_DN2: begin
        if (cmp_lt) begin
          ctid <= slot_rid;
          ctm  <= slot_rtime;
          nxt  <= nxt + IW'(1);
        end
      end
      imhq_pkg::S_DNCMP: begin
        if (!cmp_lt) pos <= nxt;
      end
      imhq_pkg::S_FRONTRD: begin
        rsp.front_id    <= (held_count == '0) ? 6'd0 : 6'(slot_rid);
        rsp.front_time  <= (held_count == '0) ? 32'd0 : 32'(slot_rtime);
        rsp.event_count <= 7'(held_count);
        rsp.assigned_id <= assigned;
        rsp.status      <= status;
      end
      default: ;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    LW'(held_count) <= LW'(CAPACITY))
    else $error("event count above capacity");

  a_count_step : assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && held_count != $past(held_count))
      |-> (held_count == $past(held_count) + CW'(1) && $past(req_acc)))
    else $error("event count moved without an accepted add");

  a_no_early_rsp : assert property (@(posedge clk) disable iff (rst)
    req_acc |=> !rsp_valid)
    else $error("result shown in the cycle after acceptance");

  a_update_keeps_count : assert property (@(posedge clk) disable iff (rst)
    (req_acc && req.cmd == imhq_pkg::CMD_UPDATE) |=> $stable(held_count))
    else $error("update changed the event count");
`endif

endmodule
`default_nettype wire
